[rtl/tct_pkg.sv]
package tct_pkg;

  // input item kinds
  localparam logic KIND_TOUCH = 1'b0;
  localparam logic KIND_POLL  = 1'b1;

  // touch event types
  localparam logic [1:0] EV_DOWN = 2'd0;
  localparam logic [1:0] EV_MOVE = 2'd1;
  localparam logic [1:0] EV_UP   = 2'd2;

  // field widths fixed by the interface
  localparam int ID_W    = 6;
  localparam int COORD_W = 16;
  localparam int STAMP_W = 32;
  localparam int TMO_W   = 16;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;

  // one stored contact
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] width_x;
    logic [COORD_W-1:0] width_y;
  } entry_t;

  // sweep sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FLUSH
  } state_t;

endpackage

[rtl/tct_entry_ram.sv]
module tct_entry_ram
  import tct_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/touch_contact_table_with_timeout_top.sv]
// Contact table with timeout. A touch word (kind 0) is taken while busy is low, so touch
// words may arrive on every clock while no sweep runs. A poll word (kind 1) starts a sweep
// over all ID_COUNT identifiers; each identifier takes a read of the entry RAM and then
// an age compare in the shared 32-bit subtract/compare unit, and a flush step at the end
// sends the held final word; busy stays high through the sweep. Expired contacts come out
// on the up_* ports, one word per up_strobe pulse. Each hit is held until the next hit or
// the end of the sweep is known, so two words are parted by at least one RAM read, except
// that the final word may follow the one before it on the very next cycle. The final
// word's strobe comes in the cycle in which busy is low again; last_up marks it. The
// receiver cannot stall: every word must be taken in the cycle its strobe is high. The
// user must write the timeout register only while busy is low; the block does not enforce it.
module touch_contact_table_with_timeout_top
  import tct_pkg::*;
#(
  parameter int ID_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [TMO_W-1:0]   cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [1:0]         event_type,
  input  logic [ID_W-1:0]    touch_id,
  input  logic [COORD_W-1:0] x_pos,
  input  logic [COORD_W-1:0] y_pos,
  input  logic [COORD_W-1:0] x_width,
  input  logic [COORD_W-1:0] y_width,
  input  logic [STAMP_W-1:0] time_ms,
  output logic               up_strobe,
  output logic [ID_W-1:0]    up_id,
  output logic [COORD_W-1:0] up_x,
  output logic [COORD_W-1:0] up_y,
  output logic [COORD_W-1:0] up_x_width,
  output logic [COORD_W-1:0] up_y_width,
  output logic               last_up
);

  localparam int IDX_W = $clog2(ID_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ID_COUNT - 1);

  state_t state, state_next;

  logic [TMO_W-1:0]    timeout_ms;
  logic [STAMP_W-1:0]  now_ms;
  logic [ID_COUNT-1:0] entry_valid;
  logic [IDX_W-1:0]    idx;

  // held hit, sent once the next hit or the end of the sweep is known
  logic                pend_valid;
  logic [IDX_W-1:0]    pend_id;
  entry_t              pend_entry;

  logic                accept;
  logic                touch_ok;
  logic [IDX_W-1:0]    touch_idx;
  logic                touch_known;
  logic                touch_store;
  logic                touch_clear;
  entry_t              touch_entry;
  entry_t              rd_entry;
  logic [STAMP_W-1:0]  age;
  logic                hit;
  logic                emit;
  logic                emit_last;
  logic                idx_clr;
  logic                idx_inc;

  // touch word decode
  assign accept      = start && !busy;
  assign touch_idx   = IDX_W'(touch_id);
  assign touch_ok    = accept && (kind == KIND_TOUCH) && (x_width != '0) &&
                       (y_width != '0) && (32'(touch_id) < ID_COUNT);
  assign touch_known = entry_valid[touch_idx];
  assign touch_store = touch_ok && (!touch_known || (event_type == EV_MOVE));
  assign touch_clear = touch_ok && touch_known && (event_type == EV_UP);

  assign touch_entry.stamp   = time_ms;
  assign touch_entry.pos_x   = x_pos;
  assign touch_entry.pos_y   = y_pos;
  assign touch_entry.width_x = x_width;
  assign touch_entry.width_y = y_width;

  tct_entry_ram #(
    .DEPTH  (ID_COUNT),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (touch_store),
    .waddr (touch_idx),
    .wdata (touch_entry),
    .raddr (idx),
    .rdata (rd_entry)
  );

  // shared age compare, modulo 2^32
  assign age = now_ms - rd_entry.stamp;
  assign hit = (state == ST_CHECK) && entry_valid[idx] &&
               (age >= STAMP_W'(timeout_ms));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_POLL)) state_next = ST_READ;
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (idx == LAST_IDX) state_next = ST_FLUSH;
        else                 state_next = ST_READ;
      end
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = 1'b1;
    emit      = 1'b0;
    emit_last = 1'b0;
    idx_clr   = 1'b0;
    idx_inc   = 1'b0;
    case (state)
      ST_IDLE: begin
        busy    = 1'b0;
        idx_clr = 1'b1;
      end
      ST_READ: begin
      end
      ST_CHECK: begin
        emit    = hit && pend_valid;
        idx_inc = (idx != LAST_IDX);
      end
      ST_FLUSH: begin
        emit      = pend_valid;
        emit_last = pend_valid;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      timeout_ms <= TIMEOUT_RESET;
      entry_valid <= '0;
      pend_valid <= 1'b0;
      up_strobe  <= 1'b0;
      last_up    <= 1'b0;
      idx        <= '0;
    end else begin
      state     <= state_next;
      up_strobe <= emit;
      last_up   <= emit_last;
      if (cfg_we) timeout_ms <= cfg_wdata;
      if (idx_clr)      idx <= '0;
      else if (idx_inc) idx <= idx + 1'b1;
      if (touch_store) entry_valid[touch_idx] <= 1'b1;
      if (touch_clear) entry_valid[touch_idx] <= 1'b0;
      if (hit) begin
        entry_valid[idx] <= 1'b0;
        pend_valid       <= 1'b1;
      end else if (state == ST_FLUSH) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) now_ms <= time_ms;
    if (hit) begin
      pend_id    <= idx;
      pend_entry <= rd_entry;
    end
    if (emit) begin
      up_id      <= ID_W'(pend_id);
      up_x       <= pend_entry.pos_x;
      up_y       <= pend_entry.pos_y;
      up_x_width <= pend_entry.width_x;
      up_y_width <= pend_entry.width_y;
    end
  end

  // checks
  a_strobe_from_sweep: assert property (@(posedge clk) disable iff (rst)
    up_strobe |-> $past(busy))
    else $error("result word without a sweep in progress");

  a_last_ends_sweep: assert property (@(posedge clk) disable iff (rst)
    (up_strobe && last_up) |-> !busy)
    else $error("final word of a sweep while still busy");

  a_last_needs_strobe: assert property (@(posedge clk) disable iff (rst)
    last_up |-> up_strobe)
    else $error("last_up without a result word");

  a_poll_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_POLL)) |=> busy)
    else $error("poll word did not start a sweep");

  a_touch_single_cycle: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_TOUCH)) |=> !busy)
    else $error("touch word held the block busy");

endmodule
